// ----- hdl/perceptron_online_training_core_assert.svh -----
// Assertion macros shared by the perceptron training core.
`ifndef PERCEPTRON_ONLINE_TRAINING_CORE_ASSERT_SVH
`define PERCEPTRON_ONLINE_TRAINING_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define POT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define POT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define POT_ASSERT_SAME(label, ante, cons, msg)
`define POT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hdl/pot_pkg.sv -----
// Constants and codes of the perceptron training core.
package pot_pkg;

  // Default sizes.
  localparam int MAX_FEATURES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 48;

  // Field widths.
  localparam int FEATURE_BITS  = 16;
  localparam int RATE_BITS     = 16;
  localparam int COUNT_BITS    = 5;
  localparam int SLOT_BITS     = 5;
  localparam int VALUE_BITS    = 48;
  localparam int DOT_BITS      = 56;
  localparam int ERR_BITS      = 2;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register reset values.
  localparam logic [COUNT_BITS-1:0] FEATURE_COUNT_RST = 5'd16;
  localparam logic [RATE_BITS-1:0]  LEARN_RATE_RST    = 16'd6554;

  // Register word indexes.
  localparam logic REG_FEATURE_COUNT = 1'b0;
  localparam logic REG_LEARN_RATE    = 1'b1;

  // Error codes: target minus prediction.
  localparam logic [ERR_BITS-1:0] ERR_NONE = 2'b00;
  localparam logic [ERR_BITS-1:0] ERR_UP   = 2'b01;
  localparam logic [ERR_BITS-1:0] ERR_DOWN = 2'b11;

endpackage

// ----- hdl/perceptron_online_training_core.sv -----
// Perceptron trainer: feature accumulation, step activation and weight update walk.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid / in_stall   | in_feature, in_target
//  out     | output    | out_valid / out_stall | out_slot, out_value, out_predicted,
//          |           |                       | out_error, out_last
//  cfg     | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// Each feature beat runs accept with weight memory read, registered multiply
// and accumulate; in_stall is high in the multiply and accumulate states and during the walk.
// The last feature of a pattern adds a walk with a read and an update state per weight
// and then a bias state, paced by the single read port of the weight memory and the
// registered multipliers.
// The walk pauses while a result beat waits under out_stall.
// Reset is synchronous; the weight valid bits make every weight read as zero.
`include "perceptron_online_training_core_assert.svh"

module perceptron_online_training_core #(
  parameter int MAX_FEATURES = pot_pkg::MAX_FEATURES_DEF,
  parameter int WEIGHT_BITS  = pot_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Feature channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pot_pkg::FEATURE_BITS-1:0] in_feature,
  input  logic                                 in_target,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pot_pkg::SLOT_BITS-1:0]        out_slot,
  output logic signed [pot_pkg::VALUE_BITS-1:0] out_value,
  output logic                                 out_predicted,
  output logic signed [pot_pkg::ERR_BITS-1:0]  out_error,
  output logic                                 out_last,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pot_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [pot_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [pot_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int FB     = pot_pkg::FEATURE_BITS;
  localparam int RB     = pot_pkg::RATE_BITS;
  localparam int DB     = pot_pkg::DOT_BITS;
  localparam int VB     = pot_pkg::VALUE_BITS;
  localparam int SLOT_W = pot_pkg::SLOT_BITS;
  localparam int IW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int NW     = $clog2(MAX_FEATURES + 1);
  localparam int CW     = IW + 1;
  localparam int PW     = WEIGHT_BITS + FB;
  localparam int SW     = ((PW > DB) ? PW : DB) + 1;
  localparam int TW     = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;
  localparam int RT     = RB + 1;
  localparam int DW     = RT + FB;
  localparam int UW     = ((WEIGHT_BITS > DW) ? WEIGHT_BITS : DW) + 1;
  localparam int BW     = WEIGHT_BITS + 1;

  localparam logic signed [DB-1:0] DOT_MAX = {1'b0, {(DB-1){1'b1}}};
  localparam logic signed [DB-1:0] DOT_MIN = {1'b1, {(DB-1){1'b0}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_WRD  = 6'b001000,
    S_WUPD = 6'b010000,
    S_BIAS = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [pot_pkg::COUNT_BITS-1:0] fc_r;
  logic [RB-1:0]                  rate_r;

  // Pattern state.
  logic [IW-1:0]                  fidx_r;
  logic signed [DB-1:0]           dot_r;
  logic signed [WEIGHT_BITS-1:0]  bias_r;

  // Working registers.
  logic signed [FB-1:0]           feat_r;
  logic                           tgt_r;
  logic [IW-1:0]                  idx_r;
  logic signed [PW-1:0]           prod_r;
  logic                           pred_r;
  logic [pot_pkg::ERR_BITS-1:0]   err_r;
  logic [IW-1:0]                  walk_r;
  logic signed [WEIGHT_BITS-1:0]  w_r;
  logic signed [DW-1:0]           delta_r;

  // Memories and their read registers.
  logic signed [WEIGHT_BITS-1:0]  weight_mem [MAX_FEATURES];
  logic signed [FB-1:0]           feat_mem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0]        wvalid_r;
  logic signed [WEIGHT_BITS-1:0]  wrd_r;
  logic                           wrd_valid_r;
  logic signed [FB-1:0]           frd_r;

  // Output register.
  logic                           out_valid_r;
  logic [SLOT_W-1:0]              out_slot_r;
  logic signed [VB-1:0]           out_value_r;
  logic                           out_predicted_r;
  logic [pot_pkg::ERR_BITS-1:0]   out_error_r;
  logic                           out_last_r;

  // Combinational signals.
  logic                           in_acc;
  logic                           cfg_wr;
  logic [NW-1:0]                  n_w;
  logic [IW-1:0]                  idx_in;
  logic [IW-1:0]                  rd_addr;
  logic signed [WEIGHT_BITS-1:0]  w_eff;
  logic signed [PW-1:0]           prod_nxt;
  logic signed [SW-1:0]           acc_sum;
  logic signed [DB-1:0]           dot_new;
  logic                           pat_last;
  logic signed [TW-1:0]           pb_sum;
  logic                           pred_nxt;
  logic [pot_pkg::ERR_BITS-1:0]   err_nxt;
  logic signed [RT-1:0]           rate_s;
  logic signed [RT-1:0]           rate_term;
  logic signed [BW-1:0]           bias_sum;
  logic signed [WEIGHT_BITS-1:0]  bias_new;
  logic                           walk_last;
  logic signed [DW-1:0]           prd;
  logic signed [DW-1:0]           delta_nxt;
  logic signed [UW-1:0]           upd_sum;
  logic signed [WEIGHT_BITS-1:0]  w_new;
  logic signed [63:0]             w_ext;
  logic signed [63:0]             b_ext;
  logic                           out_free;
  logic                           w_we;
  logic                           out_load_w;
  logic                           out_load_b;

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration read-back.
  always_comb begin
    unique case (paddr[2])
      pot_pkg::REG_FEATURE_COUNT:
        prdata = pot_pkg::APB_DATA_BITS'(fc_r);
      pot_pkg::REG_LEARN_RATE:
        prdata = pot_pkg::APB_DATA_BITS'(rate_r);
      default: prdata = '0;
    endcase
  end

  // Active feature count and the slot of the incoming feature.
  always_comb begin
    if (fc_r == '0) begin
      n_w = NW'(1);
    end else if (32'(fc_r) > MAX_FEATURES) begin
      n_w = NW'(MAX_FEATURES);
    end else begin
      n_w = NW'(fc_r);
    end
    if (CW'(fidx_r) >= CW'(n_w)) begin
      idx_in = IW'(n_w - NW'(1));
    end else begin
      idx_in = fidx_r;
    end
  end

  // Feature phase: multiply by the stored weight, then saturating accumulate.
  always_comb begin
    w_eff    = wrd_valid_r ? wrd_r : '0;
    prod_nxt = PW'(feat_r) * PW'(w_eff);
    acc_sum  = SW'(dot_r) + SW'(prod_r);
    if ((&acc_sum[SW-1:DB-1]) || !(|acc_sum[SW-1:DB-1])) begin
      dot_new = acc_sum[DB-1:0];
    end else begin
      dot_new = acc_sum[SW-1] ? DOT_MIN : DOT_MAX;
    end
    pat_last = (CW'(idx_r) + CW'(1) == CW'(n_w));
  end

  // Step activation, error and the bias update.
  always_comb begin
    pb_sum   = TW'(bias_r) + TW'(dot_new);
    pred_nxt = !pb_sum[TW-1];
    if (tgt_r && !pred_nxt) begin
      err_nxt = pot_pkg::ERR_UP;
    end else if (!tgt_r && pred_nxt) begin
      err_nxt = pot_pkg::ERR_DOWN;
    end else begin
      err_nxt = pot_pkg::ERR_NONE;
    end
    rate_s = signed'({1'b0, rate_r});
    case (err_nxt)
      pot_pkg::ERR_UP:   rate_term = rate_s;
      pot_pkg::ERR_DOWN: rate_term = -rate_s;
      default:           rate_term = '0;
    endcase
    bias_sum = BW'(bias_r) + BW'(rate_term);
    if (bias_sum[BW-1] == bias_sum[BW-2]) begin
      bias_new = bias_sum[WEIGHT_BITS-1:0];
    end else begin
      bias_new = bias_sum[BW-1] ? W_MIN : W_MAX;
    end
  end

  // Weight walk: delta from the buffered feature, then saturating update.
  always_comb begin
    walk_last = (CW'(walk_r) + CW'(1) == CW'(n_w));
    prd       = DW'(rate_s) * DW'(frd_r);
    case (err_r)
      pot_pkg::ERR_UP:   delta_nxt = prd;
      pot_pkg::ERR_DOWN: delta_nxt = -prd;
      default:           delta_nxt = '0;
    endcase
    upd_sum = UW'(w_r) + UW'(delta_r);
    if ((&upd_sum[UW-1:WEIGHT_BITS-1]) || !(|upd_sum[UW-1:WEIGHT_BITS-1])) begin
      w_new = upd_sum[WEIGHT_BITS-1:0];
    end else begin
      w_new = upd_sum[UW-1] ? W_MIN : W_MAX;
    end
    w_ext = 64'(w_new);
    b_ext = 64'(bias_r);
  end

  // Sequencer and memory read address.
  always_comb begin
    state_nxt  = state_r;
    rd_addr    = walk_r;
    w_we       = 1'b0;
    out_load_w = 1'b0;
    out_load_b = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rd_addr = idx_in;
        if (in_acc) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rd_addr   = '0;
        state_nxt = pat_last ? S_WRD : S_IDLE;
      end
      S_WRD: begin
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        rd_addr = walk_last ? walk_r : walk_r + IW'(1);
        if (out_free) begin
          w_we       = 1'b1;
          out_load_w = 1'b1;
          state_nxt  = walk_last ? S_BIAS : S_WRD;
        end
      end
      S_BIAS: begin
        if (out_free) begin
          out_load_b = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= pot_pkg::FEATURE_COUNT_RST;
      rate_r      <= pot_pkg::LEARN_RATE_RST;
      fidx_r      <= '0;
      dot_r       <= '0;
      bias_r      <= '0;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Register writes; a new feature count restarts the pattern.
      if (cfg_wr) begin
        unique case (paddr[2])
          pot_pkg::REG_FEATURE_COUNT: begin
            fc_r   <= pwdata[pot_pkg::COUNT_BITS-1:0];
            fidx_r <= '0;
            dot_r  <= '0;
          end
          pot_pkg::REG_LEARN_RATE: rate_r <= pwdata[RB-1:0];
          default: ;
        endcase
      end else if (state_r == S_ACC) begin
        if (pat_last) begin
          fidx_r <= '0;
          dot_r  <= '0;
          bias_r <= bias_new;
        end else begin
          fidx_r <= idx_r + IW'(1);
          dot_r  <= dot_new;
        end
      end
      if (w_we) wvalid_r[walk_r] <= 1'b1;
      if (out_load_w || out_load_b) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      feat_r <= in_feature;
      tgt_r  <= in_target;
      idx_r  <= idx_in;
    end
    if (state_r == S_MUL) prod_r <= prod_nxt;
    if (state_r == S_ACC) begin
      pred_r <= pred_nxt;
      err_r  <= err_nxt;
      walk_r <= '0;
    end
    if (state_r == S_WRD) begin
      w_r     <= wrd_valid_r ? wrd_r : '0;
      delta_r <= delta_nxt;
    end
    if (out_load_w && !walk_last) walk_r <= walk_r + IW'(1);
    // Result beat.
    if (out_load_w) begin
      out_slot_r      <= SLOT_W'(walk_r);
      out_value_r     <= w_ext[VB-1:0];
      out_predicted_r <= pred_r;
      out_error_r     <= err_r;
      out_last_r      <= 1'b0;
    end else if (out_load_b) begin
      out_slot_r      <= SLOT_W'(n_w);
      out_value_r     <= b_ext[VB-1:0];
      out_predicted_r <= pred_r;
      out_error_r     <= err_r;
      out_last_r      <= 1'b1;
    end
  end

  // Weight and feature memories. The walk writes entry i while reading entry
  // i+1, except on the last entry, where the read and the write hit the same entry.
  always_ff @(posedge clk) begin
    if (in_acc) feat_mem[idx_in] <= in_feature;
    if (w_we) weight_mem[walk_r] <= w_new;
    frd_r       <= feat_mem[rd_addr];
    wrd_r       <= weight_mem[rd_addr];
    wrd_valid_r <= wvalid_r[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_value     = out_value_r;
  assign out_predicted = out_predicted_r;
  assign out_error     = out_error_r;
  assign out_last      = out_last_r;

  // Checks on the sequencer and the result beats.
  `POT_ASSERT_SAME(a_last_slot, out_valid_r && out_last_r, out_slot_r == SLOT_W'(n_w), "bias beat slot differs from feature count")
  `POT_ASSERT_SAME(a_err_pred, out_valid_r, (out_error_r == pot_pkg::ERR_NONE) || (out_error_r == pot_pkg::ERR_UP && !out_predicted_r) || (out_error_r == pot_pkg::ERR_DOWN && out_predicted_r), "error code does not match prediction")
  `POT_ASSERT_NEXT(a_accept_seq, in_valid && !in_stall, state_r == S_MUL, "accepted feature did not start the multiply")
  `POT_ASSERT_SAME(a_walk_range, (state_r == S_WRD) || (state_r == S_WUPD), CW'(walk_r) < CW'(n_w), "weight walk beyond feature count")

endmodule
